// ===== rtl/pge_pkg.sv =====
// types and constants shared by the planar glyph expander modules
`timescale 1ns / 1ps
package pge_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 3'd4;

  localparam logic [31:0] RST_FRAME_BASE  = 32'h0000_0000;
  localparam logic [11:0] RST_LINE_BYTES  = 12'd80;
  localparam logic [23:0] RST_PLANE_BYTES = 24'd20480;
  localparam logic [5:0]  RST_FONT_HEIGHT = 6'd8;
  localparam logic [3:0]  RST_PLANE_COUNT = 4'd4;

  localparam logic [7:0] DATA_ONES  = 8'hff;
  localparam logic [7:0] DATA_ZEROS = 8'h00;

  typedef struct packed {
    logic [7:0]  glyph_bits;
    logic [11:0] column;
    logic [9:0]  text_row;
    logic [4:0]  font_row;
    logic [7:0]  fore_colour;
    logic [7:0]  back_colour;
  } in_req_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [2:0]  plane_index;
    logic        last;
  } out_req_t;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [11:0] line_bytes;
    logic [23:0] plane_bytes;
    logic [5:0]  font_height;
    logic [3:0]  plane_count;
  } pge_cfg_t;

  typedef struct packed {
    logic [31:0] addr0;
    logic [7:0]  glyph_bits;
    logic [7:0]  fore_colour;
    logic [7:0]  back_colour;
  } pge_item_t;

endpackage

// ===== rtl/pge_addr_pipe.sv =====
// three stage address pipeline: cell line, line offset, frame base
`timescale 1ns / 1ps
module pge_addr_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  pge_pkg::pge_cfg_t cfg,
  input  logic              start,
  input  pge_pkg::in_req_t  in_request,
  output logic              busy,
  output logic              item_valid,
  output pge_pkg::pge_item_t item,
  input  logic              item_take
);
  import pge_pkg::*;

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        en1, en2, en3;
  logic [15:0] s1_line_r;
  logic [11:0] s1_column_r;
  logic [7:0]  s1_glyph_r, s1_fg_r, s1_bg_r;
  logic [28:0] s2_off_r;
  logic [7:0]  s2_glyph_r, s2_fg_r, s2_bg_r;
  pge_item_t   s3_item_r;
  logic [15:0] s1_line_nxt;
  logic [28:0] s2_off_nxt;
  logic [31:0] s3_addr_nxt;

  assign en3  = !s3_v_r || item_take;
  assign en2  = !s2_v_r || en3;
  assign en1  = !s1_v_r || en2;
  assign busy = !en1;

  assign s1_line_nxt = 16'({6'd0, in_request.text_row} * {10'd0, cfg.font_height})
                     + {11'd0, in_request.font_row};
  assign s2_off_nxt  = 29'({12'd0, s1_line_r} * {16'd0, cfg.line_bytes})
                     + {17'd0, s1_column_r};
  assign s3_addr_nxt = cfg.frame_base + {3'd0, s2_off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= start;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_line_r   <= s1_line_nxt;
      s1_column_r <= in_request.column;
      s1_glyph_r  <= in_request.glyph_bits;
      s1_fg_r     <= in_request.fore_colour;
      s1_bg_r     <= in_request.back_colour;
    end
    if (en2) begin
      s2_off_r   <= s2_off_nxt;
      s2_glyph_r <= s1_glyph_r;
      s2_fg_r    <= s1_fg_r;
      s2_bg_r    <= s1_bg_r;
    end
    if (en3) begin
      s3_item_r.addr0       <= s3_addr_nxt;
      s3_item_r.glyph_bits  <= s2_glyph_r;
      s3_item_r.fore_colour <= s2_fg_r;
      s3_item_r.back_colour <= s2_bg_r;
    end
  end

  assign item_valid = s3_v_r;
  assign item       = s3_item_r;

endmodule

// ===== rtl/pge_plane_emit.sv =====
// per-plane write sequencer, one frame write per cycle
`timescale 1ns / 1ps
module pge_plane_emit #(
  parameter int MAX_PLANES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pge_pkg::pge_cfg_t  cfg,
  input  logic               item_valid,
  input  pge_pkg::pge_item_t item,
  output logic               item_take,
  output logic               out_valid,
  output pge_pkg::out_req_t  out_request
);
  import pge_pkg::*;

  logic        em_v_r;
  logic [31:0] em_addr_r;
  logic [2:0]  em_plane_r;
  logic [7:0]  em_glyph_r, em_fg_r, em_bg_r;
  logic [3:0]  planes;
  logic        em_last;
  logic        em_free;
  logic        f_bit, b_bit;
  logic [7:0]  wdata;

  assign planes  = (cfg.plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : cfg.plane_count;
  assign em_last = ({1'b0, em_plane_r} + 4'd1) == planes;
  assign em_free = !em_v_r || em_last;
  assign item_take = item_valid && em_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
    end else if (em_free) begin
      em_v_r <= item_valid && (planes != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (em_free) begin
      em_addr_r  <= item.addr0;
      em_plane_r <= 3'd0;
      em_glyph_r <= item.glyph_bits;
      em_fg_r    <= item.fore_colour;
      em_bg_r    <= item.back_colour;
    end else begin
      em_addr_r  <= em_addr_r + {8'd0, cfg.plane_bytes};
      em_plane_r <= em_plane_r + 3'd1;
    end
  end

  assign f_bit = em_fg_r[em_plane_r];
  assign b_bit = em_bg_r[em_plane_r];

  always_comb begin
    unique case ({b_bit, f_bit})
      2'b11:   wdata = DATA_ONES;
      2'b10:   wdata = ~em_glyph_r;
      2'b01:   wdata = em_glyph_r;
      default: wdata = DATA_ZEROS;
    endcase
  end

  assign out_valid                 = em_v_r;
  assign out_request.write_address = em_addr_r;
  assign out_request.write_data    = wdata;
  assign out_request.plane_index   = em_plane_r;
  assign out_request.last          = em_last;

endmodule

// ===== rtl/planar_glyph_expander_top.sv =====
// top level of the planar glyph expander with its configuration registers
`timescale 1ns / 1ps
// each request is one 8-pixel font row; the block issues one frame write per
// bitplane, one per clock on out_valid, plane 0 first, last set on the final
// plane. the first write of a request reaches the ports through the three address
// stages and then the plane sequencer register, later if the sequencer is still
// busy with an earlier request. the sequencer takes a new request only when it is
// empty or on its last plane; a request gives min(plane_count, MAX_PLANES) writes,
// four by default, and one with zero planes passes through it without writes. busy
// rises only when all three address stages are full behind the sequencer. the
// receiver cannot stall: every write is shown for exactly one cycle. configuration
// is written through cfg_valid/cfg_ready, which is always ready, and should only
// change while no request is in flight.
module planar_glyph_expander_top #(
  parameter int MAX_PLANES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pge_pkg::in_req_t              in_request,
  output logic                          out_valid,
  output pge_pkg::out_req_t             out_request,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import pge_pkg::*;

  pge_cfg_t  cfg_r;
  pge_item_t item;
  logic      item_valid;
  logic      item_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_base  <= RST_FRAME_BASE;
      cfg_r.line_bytes  <= RST_LINE_BYTES;
      cfg_r.plane_bytes <= RST_PLANE_BYTES;
      cfg_r.font_height <= RST_FONT_HEIGHT;
      cfg_r.plane_count <= RST_PLANE_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_BASE:  cfg_r.frame_base  <= cfg_wdata;
        CFG_LINE_BYTES:  cfg_r.line_bytes  <= cfg_wdata[11:0];
        CFG_PLANE_BYTES: cfg_r.plane_bytes <= cfg_wdata[23:0];
        CFG_FONT_HEIGHT: cfg_r.font_height <= cfg_wdata[5:0];
        CFG_PLANE_COUNT: cfg_r.plane_count <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  pge_addr_pipe u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (start),
    .in_request (in_request),
    .busy       (busy),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  pge_plane_emit #(
    .MAX_PLANES (MAX_PLANES)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .out_valid   (out_valid),
    .out_request (out_request)
  );

endmodule

// ===== rtl/pge_checker.sv =====
// port level checks for the planar glyph expander and their bind
`timescale 1ns / 1ps
module pge_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input pge_pkg::out_req_t out_request
);
  import pge_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs not idle after reset");

  a_plane_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_request.last |=>
      out_valid && out_request.plane_index == $past(out_request.plane_index) + 3'd1)
    else $error("plane sequence broken");

  a_first_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request.plane_index != 3'd0 |->
      $past(out_valid) && !$past(out_request.last))
    else $error("request started above plane zero");

endmodule

bind planar_glyph_expander_top pge_checker u_pge_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_request (out_request)
);
